/* hw/rtl/i2cbb_pkg.sv */
`default_nettype none

package i2cbb_pkg;

  // Command codes carried in the func field
  localparam logic [2:0] CMD_NONE  = 3'd0;
  localparam logic [2:0] CMD_START = 3'd1;
  localparam logic [2:0] CMD_STOP  = 3'd2;
  localparam logic [2:0] CMD_WRITE = 3'd3;
  localparam logic [2:0] CMD_WACK  = 3'd4;
  localparam logic [2:0] CMD_READ  = 3'd5;

  // Configuration register indexes
  localparam logic CFG_TICKS = 1'b0;
  localparam logic CFG_POLL  = 1'b1;

  localparam int TPU_W   = 10;
  localparam int POLL_W  = 8;
  localparam int CFG_W   = 10;
  localparam int DELAY_W = 12;

  localparam logic [TPU_W-1:0]  TPU_RST  = 10'd16;
  localparam logic [POLL_W-1:0] POLL_RST = 8'd250;

  // Queue between the front and the engine
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam int IN_DATA_W  = 16;
  localparam int IN_USER_W  = 3;
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic [2:0] cmd;
    logic [7:0] wbyte;
    logic       give_ack;
    logic       sda;
  } item_t;

endpackage

`default_nettype wire

/* hw/rtl/i2cbb_front.sv */
`default_nettype none

module i2cbb_front (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire  [i2cbb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  input  wire  [i2cbb_pkg::IN_USER_W-1:0]    s_axis_tuser,
  output logic                               q_valid_o,
  input  wire                                q_pop_i,
  output i2cbb_pkg::item_t                   q_item_o
);

  i2cbb_pkg::item_t                 mem_q [i2cbb_pkg::QDEPTH];
  i2cbb_pkg::item_t                 item_in;
  logic [i2cbb_pkg::QPTR_W-1:0]     wr_q, rd_q;
  logic [i2cbb_pkg::QCNT_W-1:0]     cnt_q;
  logic                             push, pop;

  // Classify the command: unknown codes behave as no command
  always_comb begin
    item_in.cmd      = (s_axis_tuser inside {[i2cbb_pkg::CMD_START:i2cbb_pkg::CMD_READ]})
                       ? s_axis_tuser : i2cbb_pkg::CMD_NONE;
    item_in.wbyte    = s_axis_tdata[7:0];
    item_in.give_ack = s_axis_tdata[8];
    item_in.sda      = s_axis_tdata[9];
  end

  assign s_axis_tready = (cnt_q != i2cbb_pkg::QCNT_W'(i2cbb_pkg::QDEPTH));
  assign push          = s_axis_tvalid && s_axis_tready;
  assign q_valid_o     = (cnt_q != '0);
  assign pop           = q_pop_i && q_valid_o;
  assign q_item_o      = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= item_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) begin
        wr_q <= (wr_q == i2cbb_pkg::QPTR_W'(i2cbb_pkg::QDEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop) begin
        rd_q <= (rd_q == i2cbb_pkg::QPTR_W'(i2cbb_pkg::QDEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      case ({push, pop})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/i2cbb_engine.sv */
`default_nettype none

module i2cbb_engine (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 cfg_we_i,
  input  wire                                 cfg_idx_i,
  input  wire  [i2cbb_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire                                 q_valid_i,
  output logic                                q_pop_o,
  input  wire  i2cbb_pkg::item_t              q_item_i,
  output logic                                m_axis_tvalid,
  input  wire                                 m_axis_tready,
  output logic [i2cbb_pkg::OUT_DATA_W-1:0]    m_axis_tdata
);

  localparam logic [3:0] PH_IDLE    = 4'd0;
  localparam logic [3:0] PH_ST_A    = 4'd1;
  localparam logic [3:0] PH_ST_B    = 4'd2;
  localparam logic [3:0] PH_SP_A    = 4'd3;
  localparam logic [3:0] PH_SP_B    = 4'd4;
  localparam logic [3:0] PH_WA_A    = 4'd5;
  localparam logic [3:0] PH_WA_B    = 4'd6;
  localparam logic [3:0] PH_WA_POLL = 4'd7;
  localparam logic [3:0] PH_WB_A    = 4'd8;
  localparam logic [3:0] PH_WB_B    = 4'd9;
  localparam logic [3:0] PH_WB_C    = 4'd10;
  localparam logic [3:0] PH_RB_A    = 4'd11;
  localparam logic [3:0] PH_RB_B    = 4'd12;
  localparam logic [3:0] PH_RA_A    = 4'd13;
  localparam logic [3:0] PH_RA_B    = 4'd14;

  // Delay length as a shift of the unit: 1, 2 or 4 units
  localparam logic [1:0] U1 = 2'd0;
  localparam logic [1:0] U2 = 2'd1;
  localparam logic [1:0] U4 = 2'd2;

  logic [i2cbb_pkg::TPU_W-1:0]   tpu_q;
  logic [i2cbb_pkg::POLL_W-1:0]  limit_q;

  logic [3:0]                    phase_q, phase_d;
  logic [3:0]                    bit_q, bit_d;
  logic [7:0]                    shift_q, shift_d;
  logic [i2cbb_pkg::DELAY_W-1:0] delay_q, delay_d;
  logic [7:0]                    poll_q, poll_d;
  logic                          scl_q, scl_d, sda_q, sda_d, oe_q, oe_d;
  logic                          ack_q, ack_d, choice_q, choice_d;
  logic [7:0]                    rd_q, rd_d;
  logic                          done;
  logic [3:0]                    bit_inc;
  logic                          step;
  logic                          out_valid_q;
  logic [i2cbb_pkg::OUT_DATA_W-1:0] out_data_q;

  function automatic logic [i2cbb_pkg::DELAY_W-1:0] unit_delay(
    input logic [1:0]                  sh,
    input logic [i2cbb_pkg::TPU_W-1:0] tpu
  );
    logic [i2cbb_pkg::DELAY_W-1:0] t;
    t = (tpu == '0) ? i2cbb_pkg::DELAY_W'(1)
                    : {{(i2cbb_pkg::DELAY_W - i2cbb_pkg::TPU_W){1'b0}}, tpu};
    return (t << sh) - i2cbb_pkg::DELAY_W'(1);
  endfunction

  // Advance one tick whenever a queued beat is waiting and the output stage can take it
  assign step    = q_valid_i && (!out_valid_q || m_axis_tready);
  assign q_pop_o = step;
  assign bit_inc = bit_q + 4'd1;

  always_comb begin
    phase_d  = phase_q;
    bit_d    = bit_q;
    shift_d  = shift_q;
    delay_d  = delay_q;
    poll_d   = poll_q;
    scl_d    = scl_q;
    sda_d    = sda_q;
    oe_d     = oe_q;
    ack_d    = ack_q;
    choice_d = choice_q;
    rd_d     = rd_q;
    done     = 1'b0;

    if (phase_q == PH_IDLE) begin
      case (q_item_i.cmd)
        i2cbb_pkg::CMD_START: begin
          oe_d = 1'b1; sda_d = 1'b1; scl_d = 1'b1;
          phase_d = PH_ST_A; delay_d = unit_delay(U4, tpu_q);
        end
        i2cbb_pkg::CMD_STOP: begin
          oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
          phase_d = PH_SP_A; delay_d = unit_delay(U4, tpu_q);
        end
        i2cbb_pkg::CMD_WRITE: begin
          oe_d = 1'b1; scl_d = 1'b0; bit_d = '0;
          sda_d = q_item_i.wbyte[7];
          shift_d = {q_item_i.wbyte[6:0], 1'b0};
          phase_d = PH_WB_A; delay_d = unit_delay(U2, tpu_q);
        end
        i2cbb_pkg::CMD_WACK: begin
          oe_d = 1'b0; sda_d = 1'b1;
          phase_d = PH_WA_A; delay_d = unit_delay(U1, tpu_q);
        end
        i2cbb_pkg::CMD_READ: begin
          oe_d = 1'b0; choice_d = q_item_i.give_ack;
          shift_d = '0; bit_d = '0; scl_d = 1'b0;
          phase_d = PH_RB_A; delay_d = unit_delay(U2, tpu_q);
        end
        default: ;
      endcase
    end else if (phase_q == PH_WA_POLL) begin
      if (!q_item_i.sda) begin
        scl_d = 1'b0; ack_d = 1'b0; done = 1'b1;
      end else if (poll_q >= limit_q) begin
        // Time out: flag it and release the bus with a stop
        ack_d = 1'b1;
        oe_d = 1'b1; scl_d = 1'b0; sda_d = 1'b0;
        phase_d = PH_SP_A; delay_d = unit_delay(U4, tpu_q);
      end else begin
        poll_d = poll_q + 8'd1;
      end
    end else if (delay_q != '0) begin
      delay_d = delay_q - i2cbb_pkg::DELAY_W'(1);
    end else begin
      case (phase_q)
        PH_ST_A: begin
          sda_d = 1'b0; phase_d = PH_ST_B; delay_d = unit_delay(U4, tpu_q);
        end
        PH_ST_B: begin
          scl_d = 1'b0; done = 1'b1;
        end
        PH_SP_A: begin
          scl_d = 1'b1; sda_d = 1'b1;
          phase_d = PH_SP_B; delay_d = unit_delay(U4, tpu_q);
        end
        PH_SP_B: done = 1'b1;
        PH_WA_A: begin
          scl_d = 1'b1; phase_d = PH_WA_B; delay_d = unit_delay(U1, tpu_q);
        end
        PH_WA_B: begin
          phase_d = PH_WA_POLL; poll_d = '0;
        end
        PH_WB_A: begin
          scl_d = 1'b1; phase_d = PH_WB_B; delay_d = unit_delay(U2, tpu_q);
        end
        PH_WB_B: begin
          scl_d = 1'b0; phase_d = PH_WB_C; delay_d = unit_delay(U2, tpu_q);
        end
        PH_WB_C: begin
          bit_d = bit_inc;
          if (bit_inc[3]) begin
            done = 1'b1;
          end else begin
            sda_d = shift_q[7];
            shift_d = {shift_q[6:0], 1'b0};
            phase_d = PH_WB_A; delay_d = unit_delay(U2, tpu_q);
          end
        end
        PH_RB_A: begin
          scl_d = 1'b1;
          shift_d = {shift_q[6:0], q_item_i.sda};
          phase_d = PH_RB_B; delay_d = unit_delay(U1, tpu_q);
        end
        PH_RB_B: begin
          bit_d = bit_inc; scl_d = 1'b0;
          if (bit_inc[3]) begin
            oe_d = 1'b1; sda_d = !choice_q;
            phase_d = PH_RA_A;
          end else begin
            phase_d = PH_RB_A;
          end
          delay_d = unit_delay(U2, tpu_q);
        end
        PH_RA_A: begin
          scl_d = 1'b1; phase_d = PH_RA_B; delay_d = unit_delay(U2, tpu_q);
        end
        PH_RA_B: begin
          scl_d = 1'b0; rd_d = shift_q; done = 1'b1;
        end
        default: done = 1'b1;
      endcase
    end

    if (done) begin
      phase_d = PH_IDLE;
      delay_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tpu_q       <= i2cbb_pkg::TPU_RST;
      limit_q     <= i2cbb_pkg::POLL_RST;
      phase_q     <= PH_IDLE;
      bit_q       <= '0;
      shift_q     <= '0;
      delay_q     <= '0;
      poll_q      <= '0;
      scl_q       <= 1'b1;
      sda_q       <= 1'b1;
      oe_q        <= 1'b1;
      ack_q       <= 1'b0;
      choice_q    <= 1'b0;
      rd_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          i2cbb_pkg::CFG_TICKS: tpu_q   <= cfg_data_i[i2cbb_pkg::TPU_W-1:0];
          i2cbb_pkg::CFG_POLL:  limit_q <= cfg_data_i[i2cbb_pkg::POLL_W-1:0];
          default: ;
        endcase
      end
      if (step) begin
        phase_q  <= phase_d;
        bit_q    <= bit_d;
        shift_q  <= shift_d;
        delay_q  <= delay_d;
        poll_q   <= poll_d;
        scl_q    <= scl_d;
        sda_q    <= sda_d;
        oe_q     <= oe_d;
        ack_q    <= ack_d;
        choice_q <= choice_d;
        rd_q     <= rd_d;
      end
      if (step) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_data_q <= {2'b00, ack_d, rd_d, done, (phase_d != PH_IDLE), oe_d, sda_d, scl_d};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

`ifndef SYNTHESIS
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && done |=> phase_q == PH_IDLE)
    else $error("engine not idle after command end");

  a_idle_no_delay: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_IDLE |-> delay_q == '0)
    else $error("delay left running in idle");

  a_poll_released: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_WA_POLL |-> !oe_q && scl_q)
    else $error("ack poll with SDA driven or SCL low");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready |=> $stable(phase_q) && $stable(delay_q))
    else $error("engine advanced while result stalled");
`endif

endmodule

`default_nettype wire

/* hw/rtl/i2c_bitbang_byte_master.sv */
`default_nettype none

// Channel   Dir  Payload
// s_axis    in   tuser: func[2:0]; tdata: write_byte[7:0], give_ack[8], sda_level[9]
// m_axis    out  tdata: scl_level, sda_drive, sda_is_output, busy_res, cmd_done,
//                read_byte[12:5], ack_missing[13]
// cfg       in   cfg_idx_i 0 ticks_per_unit, 1 ack_poll_limit
//
// One beat in, one beat out, one beat per cycle sustained while m_axis is ready;
// the engine advances one tick per beat and a two-entry queue separates it from
// the input side. Each beat is queued, and its result is registered on output.
// Reset puts SCL and SDA high with SDA driven and the engine idle.
// A stall on m_axis holds the engine; the queue keeps taking beats until full.

module i2c_bitbang_byte_master (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  input  wire                                cfg_we_i,
  input  wire                                cfg_idx_i,
  input  wire  [i2cbb_pkg::CFG_W-1:0]        cfg_data_i,
  input  wire                                s_axis_tvalid,
  output logic                               s_axis_tready,
  // func[2:0]
  input  wire  [i2cbb_pkg::IN_USER_W-1:0]    s_axis_tuser,
  // write_byte[7:0], give_ack[8], sda_level[9], zero fill
  input  wire  [i2cbb_pkg::IN_DATA_W-1:0]    s_axis_tdata,
  output logic                               m_axis_tvalid,
  input  wire                                m_axis_tready,
  // scl_level[0], sda_drive[1], sda_is_output[2], busy_res[3], cmd_done[4],
  // read_byte[12:5], ack_missing[13], zero fill
  output logic [i2cbb_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

  logic             q_valid;
  logic             q_pop;
  i2cbb_pkg::item_t q_item;

  i2cbb_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_valid_o     (q_valid),
    .q_pop_i       (q_pop),
    .q_item_o      (q_item)
  );

  i2cbb_engine u_engine (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .q_valid_i     (q_valid),
    .q_pop_o       (q_pop),
    .q_item_i      (q_item),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

`default_nettype wire

/* dv/i2c_bitbang_byte_master_test.sv */
`default_nettype none

module i2c_bitbang_byte_master_test;
  import i2cbb_pkg::*;

  localparam int QUIET_LIMIT = 2000;

  // Result fields, lowest bit first: scl, sda, sda_oe, busy, done, rbyte, nack
  typedef struct packed {
    logic       nack;
    logic [7:0] rbyte;
    logic       done;
    logic       busy;
    logic       sda_oe;
    logic       sda;
    logic       scl;
  } pins_t;

  typedef enum logic [3:0] {
    PH_IDLE, PH_START_HI, PH_START_LO, PH_STOP_LO, PH_STOP_HI,
    PH_ACK_REL, PH_ACK_HI, PH_ACK_POLL, PH_BIT_SET, PH_BIT_HI, PH_BIT_LO,
    PH_RD_LO, PH_RD_HI, PH_RACK_LO, PH_RACK_HI
  } phase_e;

  class pin_scoreboard;
    logic [TPU_W-1:0]  tpu;
    logic [POLL_W-1:0] poll_lim;
    phase_e            ph;
    logic [3:0]        nbits;
    logic [7:0]        shreg;
    logic [11:0]       dly;
    logic [7:0]        npoll;
    logic              scl, sda, oe, nack, ack_sel;
    logic [7:0]        rreg;
    pins_t             pin_levels_q[$];
    int unsigned       errors;
    int unsigned       beats;

    function void reset_state();
      tpu = TPU_RST;
      poll_lim = POLL_RST;
      ph = PH_IDLE;
      nbits = '0;
      shreg = '0;
      dly = '0;
      npoll = '0;
      scl = 1'b1;
      sda = 1'b1;
      oe = 1'b1;
      nack = 1'b0;
      ack_sel = 1'b0;
      rreg = '0;
      errors = 0;
      beats = 0;
    endfunction

    function void write_reg(logic idx, logic [CFG_W-1:0] val);
      if (idx == CFG_TICKS) tpu = val[TPU_W-1:0];
      else poll_lim = val[POLL_W-1:0];
    endfunction

    // hold the pins for units*tpu ticks; a zero tick count acts as one
    function void load(phase_e p, int unsigned units);
      int unsigned eff;
      eff = (tpu == 0) ? 1 : tpu;
      ph = p;
      dly = 12'(units * eff - 1);
    endfunction

    function void shift_out();
      sda = shreg[7];
      shreg = {shreg[6:0], 1'b0};
      load(PH_BIT_SET, 2);
    endfunction

    function void begin_stop();
      oe = 1'b1;
      scl = 1'b0;
      sda = 1'b0;
      load(PH_STOP_LO, 4);
    endfunction

    function void note_beat(item_t it);
      logic fin;
      fin = 1'b0;
      if (ph == PH_IDLE) begin
        case (it.cmd)
          CMD_START: begin
            oe = 1'b1;
            sda = 1'b1;
            scl = 1'b1;
            load(PH_START_HI, 4);
          end
          CMD_STOP: begin_stop();
          CMD_WRITE: begin
            oe = 1'b1;
            scl = 1'b0;
            shreg = it.wbyte;
            nbits = '0;
            shift_out();
          end
          CMD_WACK: begin
            oe = 1'b0;
            sda = 1'b1;
            load(PH_ACK_REL, 1);
          end
          CMD_READ: begin
            oe = 1'b0;
            ack_sel = it.give_ack;
            shreg = '0;
            nbits = '0;
            scl = 1'b0;
            load(PH_RD_LO, 2);
          end
          default: ;
        endcase
      end else if (ph == PH_ACK_POLL) begin
        if (!it.sda) begin
          scl = 1'b0;
          nack = 1'b0;
          fin = 1'b1;
        end else if (npoll >= poll_lim) begin
          nack = 1'b1;
          begin_stop();
        end else begin
          npoll++;
        end
      end else if (dly != 0) begin
        dly--;
      end else begin
        case (ph)
          PH_START_HI: begin
            sda = 1'b0;
            load(PH_START_LO, 4);
          end
          PH_START_LO: begin
            scl = 1'b0;
            fin = 1'b1;
          end
          PH_STOP_LO: begin
            scl = 1'b1;
            sda = 1'b1;
            load(PH_STOP_HI, 4);
          end
          PH_STOP_HI: fin = 1'b1;
          PH_ACK_REL: begin
            scl = 1'b1;
            load(PH_ACK_HI, 1);
          end
          PH_ACK_HI: begin
            ph = PH_ACK_POLL;
            npoll = '0;
          end
          PH_BIT_SET: begin
            scl = 1'b1;
            load(PH_BIT_HI, 2);
          end
          PH_BIT_HI: begin
            scl = 1'b0;
            load(PH_BIT_LO, 2);
          end
          PH_BIT_LO: begin
            nbits++;
            if (nbits >= 8) fin = 1'b1;
            else shift_out();
          end
          // sample SDA on the tick SCL rises
          PH_RD_LO: begin
            scl = 1'b1;
            shreg = {shreg[6:0], it.sda};
            load(PH_RD_HI, 1);
          end
          PH_RD_HI: begin
            nbits++;
            scl = 1'b0;
            if (nbits >= 8) begin
              oe = 1'b1;
              sda = !ack_sel;
              load(PH_RACK_LO, 2);
            end else begin
              load(PH_RD_LO, 2);
            end
          end
          PH_RACK_LO: begin
            scl = 1'b1;
            load(PH_RACK_HI, 2);
          end
          PH_RACK_HI: begin
            scl = 1'b0;
            rreg = shreg;
            fin = 1'b1;
          end
          default: fin = 1'b1;
        endcase
      end
      if (fin) begin
        ph = PH_IDLE;
        dly = '0;
      end
      pin_levels_q.push_back({nack, rreg, fin, ph != PH_IDLE, oe, sda, scl});
    endfunction

    task report(string what);
      $display("ERROR: %s", what);
      errors++;
    endtask

    task cmp(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("beat %0d %s got 0x%0h want 0x%0h", beats, name, got, want));
    endtask

    task check_beat(logic [OUT_DATA_W-1:0] tdata);
      pins_t got, want;
      got = pins_t'(tdata[13:0]);
      beats++;
      if (pin_levels_q.size() == 0) begin
        report($sformatf("beat %0d arrived with nothing outstanding", beats));
        return;
      end
      want = pin_levels_q.pop_front();
      cmp("scl_level", 8'(got.scl), 8'(want.scl));
      cmp("sda_drive", 8'(got.sda), 8'(want.sda));
      cmp("sda_is_output", 8'(got.sda_oe), 8'(want.sda_oe));
      cmp("busy_res", 8'(got.busy), 8'(want.busy));
      cmp("cmd_done", 8'(got.done), 8'(want.done));
      cmp("read_byte", got.rbyte, want.rbyte);
      cmp("ack_missing", 8'(got.nack), 8'(want.nack));
    endtask
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic                  cfg_idx_i;
  logic [CFG_W-1:0]      cfg_data_i;
  logic                  s_axis_tvalid;
  wire                   s_axis_tready;
  logic [IN_USER_W-1:0]  s_axis_tuser;   // func[2:0]
  logic [IN_DATA_W-1:0]  s_axis_tdata;   // write_byte[7:0], give_ack, sda_level
  wire                   m_axis_tvalid;
  logic                  m_axis_tready;
  wire  [OUT_DATA_W-1:0] m_axis_tdata;   // scl, sda, sda_oe, busy, done, rbyte, nack

  pin_scoreboard sb;
  int unsigned   idle_pct;
  int unsigned   stall_pct;
  int unsigned   hold_req;
  int unsigned   hold_left;
  int unsigned   quiet;
  logic          sda_cur;
  int unsigned   sda_run;
  int unsigned   run_max;

  int unsigned tpu_set[5]  = '{1, 2, 0, 3, 1};
  int unsigned poll_set[5] = '{2, 0, 5, 10'h3ff, 1};
  int unsigned runs_set[5] = '{4, 3, 8, 400, 2};

  i2c_bitbang_byte_master dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) sb.check_beat(m_axis_tdata);
    if (hold_req != 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task send_beat(item_t it);
    while ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {6'b0, it.sda, it.give_ack, it.wbyte};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_beat(it);
  endtask

  function automatic logic pick_sda(int unsigned mode);
    return (mode == 2) ? 1'($urandom_range(1)) : mode[0];
  endfunction

  // sda arrives in runs so that ACK waits see both quick ACKs and timeouts
  function automatic item_t next_tick_item();
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    if (r < 12) it.cmd = 3'($urandom_range(CMD_START, CMD_READ));
    else if (r < 15) it.cmd = 3'(CMD_READ + $urandom_range(1, 2));
    else it.cmd = CMD_NONE;
    it.wbyte = 8'($urandom_range(255));
    it.give_ack = 1'($urandom_range(1));
    if (sda_run == 0) begin
      sda_cur = 1'($urandom_range(1));
      sda_run = $urandom_range(1, run_max);
    end
    sda_run--;
    it.sda = sda_cur;
    return it;
  endfunction

  // issue one command, then tick with no command until the engine is idle
  task run_cmd(logic [2:0] cmd, logic [7:0] wb, logic ga, int unsigned sda_mode);
    item_t it;
    it = '{cmd: cmd, wbyte: wb, give_ack: ga, sda: pick_sda(sda_mode)};
    send_beat(it);
    while (sb.ph != PH_IDLE) begin
      it.cmd = CMD_NONE;
      it.sda = pick_sda(sda_mode);
      send_beat(it);
    end
  endtask

  task drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.pin_levels_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task program_regs(logic [CFG_W-1:0] tpu, logic [CFG_W-1:0] poll);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_TICKS;
    cfg_data_i <= tpu;
    @(posedge clk_i);
    sb.write_reg(CFG_TICKS, tpu);
    cfg_idx_i  <= CFG_POLL;
    cfg_data_i <= poll;
    @(posedge clk_i);
    sb.write_reg(CFG_POLL, poll);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task set_idling(int unsigned mode);
    case (mode)
      0: begin idle_pct = 0;  stall_pct = 0;  end
      1: begin idle_pct = 46; stall_pct = 0;  end
      2: begin idle_pct = 0;  stall_pct = 46; end
      default: begin idle_pct = 6; stall_pct = 6; end
    endcase
  endtask

  initial begin
    item_t it;
    sb = new();
    sb.reset_state();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_TICKS;
    cfg_data_i = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tuser = CMD_NONE;
    s_axis_tdata = '0;
    m_axis_tready = 1'b0;
    idle_pct = 0;
    stall_pct = 0;
    hold_req = 0;
    hold_left = 0;
    quiet = 0;
    sda_cur = 1'b1;
    sda_run = 0;
    run_max = 4;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed commands at the shortest timing
    program_regs(10'd1, 10'd2);
    run_cmd(CMD_START, 8'h00, 1'b0, 0);
    run_cmd(CMD_WRITE, 8'hff, 1'b0, 0);
    run_cmd(CMD_WRITE, 8'h00, 1'b1, 1);
    run_cmd(CMD_WRITE, 8'ha5, 1'b0, 2);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 0);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 1);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 2);
    run_cmd(CMD_READ, 8'h00, 1'b1, 2);
    run_cmd(CMD_READ, 8'h00, 1'b0, 2);
    run_cmd(CMD_READ, 8'h3c, 1'b1, 1);
    run_cmd(CMD_READ, 8'hc3, 1'b0, 0);
    run_cmd(CMD_STOP, 8'h00, 1'b0, 0);
    run_cmd(3'(CMD_READ + 1), 8'hff, 1'b1, 1);
    run_cmd(3'(CMD_READ + 2), 8'hff, 1'b1, 1);
    // a write offered while a start is running must be dropped
    it = '{cmd: CMD_START, wbyte: 8'h81, give_ack: 1'b0, sda: 1'b0};
    send_beat(it);
    it.cmd = CMD_WRITE;
    send_beat(it);
    run_cmd(CMD_NONE, 8'h00, 1'b0, 0);
    drain();

    for (int p = 0; p < 5; p++) begin
      program_regs(CFG_W'(tpu_set[p]), CFG_W'(poll_set[p]));
      set_idling(p % 4);
      run_max = runs_set[p];
      for (int k = 0; k < 50; k++) begin
        // stall the output long enough for the input side to back up
        if (p == 0 && k == 20) hold_req = 80;
        send_beat(next_tick_item());
      end
      run_cmd(CMD_NONE, 8'h00, 1'b0, 0);
      drain();
    end

    // longest poll limit, timed out
    set_idling(0);
    program_regs(10'd1, 10'd255);
    run_cmd(CMD_WACK, 8'h00, 1'b0, 1);
    drain();
    repeat (20) @(posedge clk_i);

    if (sb.pin_levels_q.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pin_levels_q.size()));
    if (sb.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

`default_nettype wire

/* filelist.f */
hw/rtl/i2cbb_pkg.sv
hw/rtl/i2cbb_front.sv
hw/rtl/i2cbb_engine.sv
hw/rtl/i2c_bitbang_byte_master.sv
dv/i2c_bitbang_byte_master_test.sv
